[rtl/core/cbf_pkg.sv]
// shared types and codes for the bounded channel fifo with close
// no dependencies
package cbf_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CAP_W    = 5;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_SEND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECV  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCK  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] send_value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  recv_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic exec;        // execute the item on the input port
    logic cfg_we;      // capacity register write
    logic load_rdata;  // capture slot read data into the result
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic recv_hit;    // item is a receive that dequeues a slot
  } dp_stat_t;

endpackage

[rtl/core/cbf_ram.sv]
// generic single write port ram with registered read
// no dependencies
module cbf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                    wdata_i,
  input  logic                                re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/cbf_ctrl.sv]
// handshake controller: sequences one item at a time and owns result valid
// depends on cbf_pkg
module cbf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cbf_pkg::dp_stat_t    stat_i,
  output cbf_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        exec;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign exec        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (exec && stat_i.recv_hit) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    // dequeuing receive results wait in S_READ for the slot read
    if ((exec && !stat_i.recv_hit) || (state_q == S_READ)) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cmd_o.exec       = exec;
  assign cmd_o.cfg_we     = cfg_valid_i && cfg_ready_o;
  assign cmd_o.load_rdata = (state_q == S_READ);

`ifndef SYNTHESIS
  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_IDLE))
    else $error("read state lasted more than one cycle");

  a_read_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q)
    else $error("result register busy while slot data arrives");

  a_hit_enters_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && stat_i.recv_hit) |=> (state_q == S_READ) && !out_valid_q)
    else $error("dequeue did not wait for slot read");
`endif

endmodule

[rtl/core/cbf_dp.sv]
// datapath: indices, fill count, closed flag, capacity, slot ram, result register
// depends on cbf_pkg and cbf_ram
module cbf_dp #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cbf_pkg::in_item_t               in_item_i,
  input  logic [cbf_pkg::CAP_W-1:0]       cfg_data_i,
  input  cbf_pkg::ctrl_cmd_t              cmd_i,
  output cbf_pkg::dp_stat_t               stat_o,
  output cbf_pkg::out_item_t              out_item_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic             closed_q, closed_d;

  logic [cbf_pkg::STATUS_W-1:0] status;
  logic                         do_write;
  logic                         do_read;
  logic                         full;
  logic [CNT_W:0]               wr_inc;
  logic [CNT_W:0]               rd_inc;
  logic [IDX_W-1:0]             wr_next;
  logic [IDX_W-1:0]             rd_next;
  logic [63:0]                  wdata_wide;
  logic [63:0]                  rdata_wide;
  logic [ELEM_BITS-1:0]         rdata;
  logic [CNT_W-1:0]             cap_new;

  cbf_pkg::out_item_t out_q;

  assign full   = (fill_q >= cap_q);
  assign wr_inc = (CNT_W + 1)'(wr_idx_q) + 1'b1;
  assign rd_inc = (CNT_W + 1)'(rd_idx_q) + 1'b1;
  // indices wrap at the configured capacity
  assign wr_next = (wr_inc >= (CNT_W + 1)'(cap_q)) ? '0 : IDX_W'(wr_inc);
  assign rd_next = (rd_inc >= (CNT_W + 1)'(cap_q)) ? '0 : IDX_W'(rd_inc);

  always_comb begin
    status   = cbf_pkg::ST_OK;
    do_write = 1'b0;
    do_read  = 1'b0;
    closed_d = closed_q;
    case (in_item_i.kind)
      cbf_pkg::KIND_SEND: begin
        if (closed_q) begin
          status = cbf_pkg::ST_CLOSED;
        end else if (full) begin
          status = cbf_pkg::ST_BLOCK;
        end else begin
          do_write = 1'b1;
        end
      end
      cbf_pkg::KIND_RECV: begin
        if (fill_q != '0) begin
          do_read = 1'b1;
        end else if (closed_q) begin
          status = cbf_pkg::ST_CLOSED;
        end else begin
          status = cbf_pkg::ST_BLOCK;
        end
      end
      cbf_pkg::KIND_CLOSE: begin
        closed_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign stat_o.recv_hit = do_read;

  // capacity zero acts as one, above the slot count saturates
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_new = CNT_W'(1);
    end else if (int'(cfg_data_i) > int'(DEPTH)) begin
      cap_new = CNT_W'(DEPTH);
    end else begin
      cap_new = CNT_W'(cfg_data_i);
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    fill_d   = fill_q;
    cap_d    = cap_q;
    if (cmd_i.cfg_we && (fill_q == '0)) begin
      cap_d    = cap_new;
      rd_idx_d = '0;
      wr_idx_d = '0;
    end
    if (cmd_i.exec) begin
      if (do_write) begin
        wr_idx_d = wr_next;
        fill_d   = fill_q + 1'b1;
      end
      if (do_read) begin
        rd_idx_d = rd_next;
        fill_d   = fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      fill_q   <= '0;
      cap_q    <= CNT_W'(DEPTH);
      closed_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      fill_q   <= fill_d;
      cap_q    <= cap_d;
      if (cmd_i.exec) begin
        closed_q <= closed_d;
      end
    end
  end

  assign wdata_wide = 64'(in_item_i.send_value);

  cbf_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && do_write),
    .waddr_i (wr_idx_q),
    .wdata_i (wdata_wide[ELEM_BITS-1:0]),
    .re_i    (cmd_i.exec && do_read),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  assign rdata_wide = 64'(rdata);

  // result register: status at execute, slot data in the cycle after
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q.status     <= status;
      out_q.recv_value <= '0;
    end else if (cmd_i.load_rdata) begin
      out_q.recv_value <= rdata_wide[cbf_pkg::VALUE_W-1:0];
    end
  end

  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("fill count above capacity");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed flag cleared");

  a_full_send_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !cmd_i.cfg_we && in_item_i.kind == cbf_pkg::KIND_SEND && full)
      |=> $stable(fill_q) && $stable(wr_idx_q))
    else $error("send to full channel changed state");
`endif

endmodule

[rtl/core/bounded_channel_fifo_with_close_top.sv]
// top level of the bounded channel fifo with close
// depends on cbf_pkg, cbf_ctrl, cbf_dp
// results: send, close and failed receive register their result at accept,
// a dequeuing receive after the read state (registered slot ram read)
// throughput: 1 item per cycle while results are taken, none in the read state
// reset: asynchronous active low, channel empty and open, capacity DEPTH,
// slot contents undefined until written
module bounded_channel_fifo_with_close_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cbf_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cbf_pkg::out_item_t         out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cbf_pkg::CAP_W-1:0]  cfg_data_i
);

  cbf_pkg::ctrl_cmd_t cmd;
  cbf_pkg::dp_stat_t  stat;

  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cbf_dp #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule
